/* sv/mandelbrot_escape_counter_assert.svh */
// assertion macros for the mandelbrot escape counter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef MANDELBROT_ESCAPE_COUNTER_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNTER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define MBE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mbe checker: property failed");

// expression must never be true out of reset
`define MBE_ASSERT_NEVER(lbl, expr) \
    `MBE_ASSERT(lbl, !(expr))

`endif

/* sv/mbe_pkg.sv */
// shared types, constants and helper functions of the mandelbrot escape counter
// no dependencies
package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int PIX_W     = 12;
    localparam int Z_W       = 32;
    localparam int STEP_W    = 31;
    localparam int ITER_W    = 16;
    localparam int PROD_W    = 2 * Z_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam int CPROD_W = PIX_W + STEP_W;
    localparam int CSUM_W  = CPROD_W + 2;
    localparam int UPD_W   = (PROD_W - FRAC_BITS + 2 > Z_W + 2) ?
                             (PROD_W - FRAC_BITS + 2) : (Z_W + 2);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = QPTR_W + 1;
    localparam int ITEM_CAPACITY = QUEUE_DEPTH + 3;
    localparam int OUTST_W       = $clog2(ITEM_CAPACITY + 1);

    typedef logic signed [Z_W-1:0]    z_t;
    typedef logic        [STEP_W-1:0] step_t;
    typedef logic        [ITER_W-1:0] cnt_t;
    typedef logic        [PIX_W-1:0]  pix_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic        [PROD_W-1:0] mag_t;
    typedef logic        [CPROD_W-1:0] cprod_t;
    typedef logic signed [CSUM_W-1:0] csum_t;
    typedef logic signed [UPD_W-1:0]  upd_t;

    localparam bit   LIMIT_FITS = (2 * FRAC_BITS + 2) < PROD_W;
    localparam mag_t ESC_LIMIT  = LIMIT_FITS ? (mag_t'(4) << (2 * FRAC_BITS)) : mag_t'(0);

    localparam z_t   Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam z_t   Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

    localparam cnt_t  MAX_ITER_RST = cnt_t'(256);
    localparam z_t    X_MIN_RST    = 32'shE000_0000;
    localparam z_t    Y_MIN_RST    = 32'shE000_0000;
    localparam step_t X_STEP_RST   = step_t'(2097152);
    localparam step_t Y_STEP_RST   = step_t'(2097152);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER,
        CFG_X_MIN,
        CFG_Y_MIN,
        CFG_X_STEP,
        CFG_Y_STEP
    } cfg_idx_t;

    typedef struct packed {
        cnt_t  max_iter;
        z_t    x_min;
        z_t    y_min;
        step_t x_step;
        step_t y_step;
    } cfg_t;

    typedef struct packed {
        z_t cre;
        z_t cim;
    } coord_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHK,
        BK_WAIT
    } back_state_t;

    function automatic z_t sat_coord(csum_t v);
        csum_t hi;
        csum_t lo;
        hi = csum_t'(Z_MAX);
        lo = csum_t'(Z_MIN);
        if (v > hi)
            return Z_MAX;
        if (v < lo)
            return Z_MIN;
        return z_t'(v);
    endfunction

    function automatic z_t sat_upd(upd_t v);
        upd_t hi;
        upd_t lo;
        hi = upd_t'(Z_MAX);
        lo = upd_t'(Z_MIN);
        if (v > hi)
            return Z_MAX;
        if (v < lo)
            return Z_MIN;
        return z_t'(v);
    endfunction

endpackage

/* sv/mbe_ifs.sv */
// handshake channel interfaces: pixel item, result item, configuration write
// depends on mbe_pkg
interface mbe_pixel_if;
    import mbe_pkg::*;
    logic valid;
    logic ready;
    pix_t pixel_col;
    pix_t pixel_row;
    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface mbe_result_if;
    import mbe_pkg::*;
    logic valid;
    logic ready;
    cnt_t iteration_count;
    logic escaped;
    modport source (output valid, iteration_count, escaped, input ready);
    modport sink   (input valid, iteration_count, escaped, output ready);
endinterface

interface mbe_cfg_if;
    import mbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/mandelbrot_escape_counter.sv */
// top level of the mandelbrot escape counter: configuration registers,
// front, coordinate queue and back; depends on mbe_pkg, mbe_ifs and submodules
//
// channel  role  payload
// pixel    sink  pixel_col, pixel_row
// result   src   iteration_count, escaped
// cfg      sink  index, data (always ready)
//
// an accepted pixel is held in the front until the queue has room; the back
// pops it, then alternates a multiply and a check and update state until the
// point escapes or max_iterations steps are done; a zero step limit goes
// straight to the wait state; up to five items may be in flight; a stalled
// result holds the back and, once the queue fills, the front too
// reset clears all control state and restores the register defaults
module mandelbrot_escape_counter (
    input  logic        clk,
    input  logic        rst_n,
    mbe_pixel_if.sink   pixel,
    mbe_result_if.source result,
    mbe_cfg_if.sink     cfg
);
    import mbe_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_status;
    logic      push;
    coord_t    push_data;
    logic      pop;
    coord_t    pop_data;

    always_comb
    begin
        cfg.ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_MAX_ITER: cfg_next.max_iter = cfg.data[ITER_W-1:0];
                CFG_X_MIN:    cfg_next.x_min    = z_t'(cfg.data);
                CFG_Y_MIN:    cfg_next.y_min    = z_t'(cfg.data);
                CFG_X_STEP:   cfg_next.x_step   = cfg.data[STEP_W-1:0];
                CFG_Y_STEP:   cfg_next.y_step   = cfg.data[STEP_W-1:0];
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_iter <= MAX_ITER_RST;
            cfg_reg.x_min    <= X_MIN_RST;
            cfg_reg.y_min    <= Y_MIN_RST;
            cfg_reg.x_step   <= X_STEP_RST;
            cfg_reg.y_step   <= Y_STEP_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    mbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pixel     (pixel),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    mbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    mbe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_iter (cfg_reg.max_iter),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .result   (result)
    );

endmodule

/* sv/mbe_queue.sv */
// short coordinate queue between the front and the back
// depends on mbe_pkg
module mbe_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mbe_pkg::coord_t    push_data,
    input  logic               pop,
    output mbe_pkg::coord_t    pop_data,
    output mbe_pkg::q_status_t status
);
    import mbe_pkg::*;

    coord_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        pop_data     = mem_reg[rd_ptr_reg];
        wr_ptr_next  = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next  = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next   = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/mbe_front.sv */
// front part: accepts pixel items and maps them to saturated complex coordinates
// depends on mbe_pkg and mbe_ifs
module mbe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  mbe_pkg::cfg_t      cfg,
    mbe_pixel_if.sink          pixel,
    input  mbe_pkg::q_status_t q_status,
    output logic               push,
    output mbe_pkg::coord_t    push_data
);
    import mbe_pkg::*;

    logic   s1_valid_reg, s1_valid_next;
    cprod_t px_reg, px_next;
    cprod_t py_reg, py_next;
    logic   accept;
    csum_t  sum_re;
    csum_t  sum_im;

    always_comb
    begin
        pixel.ready = !s1_valid_reg || !q_status.full;
        accept      = pixel.valid && pixel.ready;
        push        = s1_valid_reg && !q_status.full;
        px_next     = cprod_t'(pixel.pixel_col) * cprod_t'(cfg.x_step);
        py_next     = cprod_t'(pixel.pixel_row) * cprod_t'(cfg.y_step);
        s1_valid_next = accept ? 1'b1 : (push ? 1'b0 : s1_valid_reg);
        sum_re      = csum_t'(cfg.x_min) + csum_t'(px_reg);
        sum_im      = csum_t'(cfg.y_min) + csum_t'(py_reg);
        push_data.cre = sat_coord(sum_re);
        push_data.cim = sat_coord(sum_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

endmodule

/* sv/mbe_back.sv */
// back part: escape-time iteration of z = z^2 + c and the result register
// depends on mbe_pkg and mbe_ifs
module mbe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mbe_pkg::cnt_t      max_iter,
    input  mbe_pkg::q_status_t q_status,
    input  mbe_pkg::coord_t    pop_data,
    output logic               pop,
    mbe_result_if.source       result
);
    import mbe_pkg::*;

    back_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;
    cnt_t        ocount_reg, ocount_next;
    logic        oesc_reg, oesc_next;
    z_t          cre_reg, cre_next;
    z_t          cim_reg, cim_next;
    z_t          zre_reg, zre_next;
    z_t          zim_reg, zim_next;
    cnt_t        iter_reg, iter_next;
    prod_t       rr_reg, rr_next;
    prod_t       ii_reg, ii_next;
    prod_t       ri_reg, ri_next;
    cnt_t        pcount_reg, pcount_next;
    logic        pesc_reg, pesc_next;
    mag_t        mag;
    logic        escape;
    prod_t       diff;
    prod_t       sh_re;
    prod_t       sh_im;
    upd_t        upd_re;
    upd_t        upd_im;
    cnt_t        iter_inc;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        ocount_next = ocount_reg;
        oesc_next   = oesc_reg;
        cre_next    = cre_reg;
        cim_next    = cim_reg;
        zre_next    = zre_reg;
        zim_next    = zim_reg;
        iter_next   = iter_reg;
        rr_next     = rr_reg;
        ii_next     = ii_reg;
        ri_next     = ri_reg;
        pcount_next = pcount_reg;
        pesc_next   = pesc_reg;
        pop         = 1'b0;

        mag      = mag_t'(rr_reg) + mag_t'(ii_reg);
        escape   = LIMIT_FITS && (mag > ESC_LIMIT);
        diff     = rr_reg - ii_reg;
        sh_re    = diff >>> FRAC_BITS;
        sh_im    = ri_reg >>> (FRAC_BITS - 1);
        upd_re   = upd_t'(sh_re) + upd_t'(cre_reg);
        upd_im   = upd_t'(sh_im) + upd_t'(cim_reg);
        iter_inc = iter_reg + cnt_t'(1);

        if (result.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop       = 1'b1;
                    cre_next  = pop_data.cre;
                    cim_next  = pop_data.cim;
                    zre_next  = pop_data.cre;
                    zim_next  = pop_data.cim;
                    iter_next = '0;
                    if (max_iter == '0)
                    begin
                        pcount_next = '0;
                        pesc_next   = 1'b0;
                        state_next  = BK_WAIT;
                    end
                    else
                        state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                rr_next    = zre_reg * zre_reg;
                ii_next    = zim_reg * zim_reg;
                ri_next    = zre_reg * zim_reg;
                state_next = BK_CHK;
            end
            BK_CHK:
            begin
                if (escape)
                begin
                    pcount_next = iter_reg;
                    pesc_next   = 1'b1;
                    state_next  = BK_WAIT;
                end
                else
                begin
                    zre_next  = sat_upd(upd_re);
                    zim_next  = sat_upd(upd_im);
                    iter_next = iter_inc;
                    if (iter_inc == max_iter)
                    begin
                        pcount_next = max_iter;
                        pesc_next   = 1'b0;
                        state_next  = BK_WAIT;
                    end
                    else
                        state_next = BK_MUL;
                end
            end
            BK_WAIT:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    ocount_next = pcount_reg;
                    oesc_next   = pesc_reg;
                    state_next  = BK_IDLE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase

        result.valid           = ovalid_reg;
        result.iteration_count = ocount_reg;
        result.escaped         = oesc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ocount_reg <= ocount_next;
        oesc_reg   <= oesc_next;
        cre_reg    <= cre_next;
        cim_reg    <= cim_next;
        zre_reg    <= zre_next;
        zim_reg    <= zim_next;
        iter_reg   <= iter_next;
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        ri_reg     <= ri_next;
        pcount_reg <= pcount_next;
        pesc_reg   <= pesc_next;
    end

endmodule

/* sv/mbe_checker.sv */
// port-level checker for the mandelbrot escape counter and its bind
// depends on mbe_pkg and mandelbrot_escape_counter_assert.svh
`include "mandelbrot_escape_counter_assert.svh"

module mbe_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          pixel_valid,
    input logic          pixel_ready,
    input logic          result_valid,
    input logic          result_ready,
    input mbe_pkg::cnt_t result_count,
    input logic          result_escaped,
    input logic          cfg_ready
);
    import mbe_pkg::*;

    logic [OUTST_W-1:0] outst_reg, outst_next;

    always_comb
    begin
        outst_next = outst_reg + OUTST_W'(pixel_valid && pixel_ready)
                   - OUTST_W'(result_valid && result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outst_reg <= '0;
        else
            outst_reg <= outst_next;
    end

    `MBE_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result_count) && $stable(result_escaped))
    `MBE_ASSERT_NEVER(a_no_invented, result_valid && (outst_reg == '0))
    `MBE_ASSERT(a_full_stall, (outst_reg == OUTST_W'(ITEM_CAPACITY)) |-> !pixel_ready)
    `MBE_ASSERT(a_cfg_ready, cfg_ready)

endmodule

bind mandelbrot_escape_counter mbe_checker u_mbe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pixel_valid    (pixel.valid),
    .pixel_ready    (pixel.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_count   (result.iteration_count),
    .result_escaped (result.escaped),
    .cfg_ready      (cfg.ready)
);

/* dv/mbe_escape_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the mandelbrot escape counter: follows register writes, predicts the
// escape count of every accepted pixel and compares it with the result channel
// depends on mbe_pkg and mbe_ifs
module mbe_escape_checker (
    input  logic  clk,
    input  logic  rst_n,
    mbe_pixel_if  pixel,
    mbe_result_if result,
    mbe_cfg_if    cfg,
    output int    fail_count,
    output int    pending_count,
    output int    escaped_count,
    output int    bounded_count
);
    import mbe_pkg::*;

    typedef struct packed {
        cnt_t count;
        logic escaped;
    } pixel_outcome_t;

    localparam bit          BOUND_FITS   = (2 * FRAC_BITS + 2) < 64;
    localparam logic [63:0] ESCAPE_BOUND = BOUND_FITS ? (64'd4 << (2 * FRAC_BITS)) : 64'd0;

    cnt_t  iter_limit;
    z_t    win_x_min;
    z_t    win_y_min;
    step_t win_x_step;
    step_t win_y_step;

    pixel_outcome_t outcome_q[$];

    function automatic z_t clamp_word(longint v);
        if (v > longint'(Z_MAX))
            return Z_MAX;
        if (v < longint'(Z_MIN))
            return Z_MIN;
        return z_t'(v);
    endfunction

    function automatic pixel_outcome_t escape_outcome(pix_t col, pix_t row);
        longint         c_re;
        longint         c_im;
        longint         z_re;
        longint         z_im;
        longint         re_sq;
        longint         im_sq;
        longint         re_im;
        logic [63:0]    mag;
        int unsigned    n;
        pixel_outcome_t res;
        c_re = clamp_word(longint'(win_x_min) + longint'(col) * longint'(win_x_step));
        c_im = clamp_word(longint'(win_y_min) + longint'(row) * longint'(win_y_step));
        z_re = c_re;
        z_im = c_im;
        res.count   = iter_limit;
        res.escaped = 1'b0;
        for (n = 0; n < iter_limit; n++)
        begin
            re_sq = z_re * z_re;
            im_sq = z_im * z_im;
            mag   = $unsigned(re_sq) + $unsigned(im_sq);
            if (BOUND_FITS && mag > ESCAPE_BOUND)
            begin
                res.count   = cnt_t'(n);
                res.escaped = 1'b1;
                return res;
            end
            re_im = z_re * z_im;
            // arithmetic shift of a signed value is a floor division
            z_re  = clamp_word(((re_sq - im_sq) >>> FRAC_BITS) + c_re);
            z_im  = clamp_word((re_im >>> (FRAC_BITS - 1)) + c_im);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_limit <= MAX_ITER_RST;
            win_x_min  <= X_MIN_RST;
            win_y_min  <= Y_MIN_RST;
            win_x_step <= X_STEP_RST;
            win_y_step <= Y_STEP_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_MAX_ITER: iter_limit <= cfg.data[ITER_W-1:0];
                CFG_X_MIN:    win_x_min  <= z_t'(cfg.data);
                CFG_Y_MIN:    win_y_min  <= z_t'(cfg.data);
                CFG_X_STEP:   win_x_step <= cfg.data[STEP_W-1:0];
                CFG_Y_STEP:   win_y_step <= cfg.data[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_outcome_t want;
        int             errs;
        int             esc;
        int             bnd;
        if (!rst_n)
        begin
            outcome_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
            escaped_count <= 0;
            bounded_count <= 0;
        end
        else
        begin
            errs = 0;
            esc  = 0;
            bnd  = 0;
            if (pixel.valid && pixel.ready)
                outcome_q.insert(outcome_q.size(),
                                 escape_outcome(pixel.pixel_col, pixel.pixel_row));
            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result item, count %0d escaped %0b", $time,
                             result.iteration_count, result.escaped);
                    errs++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (want.escaped)
                        esc = 1;
                    else
                        bnd = 1;
                    if (result.iteration_count !== want.count)
                    begin
                        $display("%0t: iteration_count mismatch, expected %0d actual %0d",
                                 $time, want.count, result.iteration_count);
                        errs++;
                    end
                    if (result.escaped !== want.escaped)
                    begin
                        $display("%0t: escaped mismatch, expected %0b actual %0b",
                                 $time, want.escaped, result.escaped);
                        errs++;
                    end
                end
            end
            fail_count    <= fail_count + errs;
            escaped_count <= escaped_count + esc;
            bounded_count <= bounded_count + bnd;
            pending_count <= outcome_q.size();
        end
    end

endmodule

/* dv/mandelbrot_escape_counter_tb.sv */
`timescale 1ns / 1ps
// top of the mandelbrot escape counter testbench: clock, reset, register settings,
// pixel stimulus and result back-pressure; checking is done by mbe_escape_checker
// depends on mbe_pkg, mbe_ifs, mbe_escape_checker and the block itself
module mandelbrot_escape_counter_tb;
    import mbe_pkg::*;

    localparam int  ONE           = 1 << FRAC_BITS;
    localparam int  RANDOM_PHASES = 8;
    localparam int  PHASE_ITEMS   = 50;
    localparam int  TIMEOUT_NS    = 10_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_Y_STEP + 1);

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   escaped_count;
    int   bounded_count;
    int   settings_count;
    bit   send_calm;
    bit   take_calm;

    mbe_pixel_if  pixel_ch();
    mbe_result_if result_ch();
    mbe_cfg_if    cfg_ch();

    mandelbrot_escape_counter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mbe_escape_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pixel_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .escaped_count (escaped_count),
        .bounded_count (bounded_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_count);
        $display("mandelbrot_escape_counter_tb NOT OK");
        $finish;
    end

    function automatic int unsigned idle_cycles(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_pixel(input pix_t col, input pix_t row);
        int unsigned gap;
        gap = idle_cycles(send_calm);
        if (gap != 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.pixel_col <= col;
        pixel_ch.pixel_row <= row;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic program_window(input cnt_t iters, input z_t xmin, input z_t ymin,
                                  input logic [CFG_DAT_W-1:0] xstep,
                                  input logic [CFG_DAT_W-1:0] ystep);
        wait_idle();
        write_reg(CFG_MAX_ITER, CFG_DAT_W'({$urandom(), iters}));
        write_reg(CFG_X_MIN, xmin);
        write_reg(CFG_Y_MIN, ymin);
        write_reg(CFG_X_STEP, xstep);
        write_reg(CFG_Y_STEP, ystep);
        write_reg(CFG_IDX_W'(CFG_SPARE + $urandom_range(0, (1 << CFG_IDX_W) - 1 - CFG_SPARE)),
                  $urandom());
        cfg_ch.valid <= 1'b0;
        settings_count++;
    endtask

    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = idle_cycles(take_calm);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int                   phase;
        int                   k;
        cnt_t                 iters;
        z_t                   xmin;
        z_t                   ymin;
        logic [CFG_DAT_W-1:0] xstep;
        logic [CFG_DAT_W-1:0] ystep;

        rst_n              <= 1'b0;
        pixel_ch.valid     <= 1'b0;
        pixel_ch.pixel_col <= '0;
        pixel_ch.pixel_row <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: from -2 in steps of 1/128, saturating just below +8
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(256, 256);
        send_pixel(128, 256);
        send_pixel(384, 256);
        send_pixel(294, 256);
        send_pixel(200, 300);

        // zero step limit
        program_window(16'd0, -2 * ONE, -2 * ONE, 32'd2097152, 32'd2097152);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 1);

        // single step, c = 1.5 would escape only at the second test, so it is reported bounded
        program_window(16'd1, 3 * ONE / 2, 0, 32'h8000_0000, 32'd0);
        send_pixel(17, 4000);
        send_pixel(4095, 0);

        // coordinate saturation with the largest step limit
        program_window(16'hFFFF, Z_MAX, Z_MIN, 32'hFFFF_FFFF, 32'h8000_0000);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        program_window(16'hFFFF, Z_MIN, Z_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(4095, 4095);
        send_pixel(1, 1);

        // origin stays bounded for the full step limit
        program_window(16'hFFFF, 0, 0, 32'd0, 32'd0);
        send_pixel(pix_t'($urandom_range(0, 4095)), pix_t'($urandom_range(0, 4095)));

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 7))
                0:       iters = 16'd0;
                1:       iters = 16'd1;
                2:       iters = cnt_t'($urandom_range(2, 16));
                6:       iters = 16'd256;
                7:       iters = cnt_t'($urandom_range(301, 600));
                default: iters = cnt_t'($urandom_range(17, 300));
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                xmin  = $urandom();
                ymin  = $urandom();
                xstep = $urandom();
                ystep = $urandom();
            end
            else
            begin
                xmin  = -int'($urandom_range(3 * ONE / 2, 5 * ONE / 2));
                ymin  = -int'($urandom_range(ONE / 2, 3 * ONE / 2));
                xstep = {1'($urandom()), STEP_W'($urandom_range(ONE / 4096, 3 * ONE / 4096))};
                ystep = {1'($urandom()), STEP_W'($urandom_range(ONE / 4096, 3 * ONE / 4096))};
            end
            program_window(iters, xmin, ymin, xstep, ystep);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_pixel(pix_t'($urandom_range(0, 4095)), pix_t'($urandom_range(0, 4095)));
        end

        wait_idle();
        repeat (64) @(posedge clk);

        $display("checked %0d pixels, %0d escaped and %0d bounded, under %0d register settings",
                 escaped_count + bounded_count, escaped_count, bounded_count, settings_count + 1);
        if (fail_count == 0)
            $display("mandelbrot_escape_counter_tb OK");
        else
            $display("mandelbrot_escape_counter_tb NOT OK");
        $finish;
    end

endmodule
